@@ rtl/core/dcip_pkg.sv @@
// Package for the delta copy/insert instruction parser.
// Holds transaction structs, code enums and size constants; no dependencies.
`default_nettype none

package dcip_pkg;

  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 2;

  localparam logic [23:0] CopyLenZero = 24'h010000;

  typedef enum logic [1:0] {
    KIND_COPY    = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_LITERAL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_COPY_START = 2'd0,
    OP_COPY_FIELD = 2'd1,
    OP_INSERT     = 2'd2,
    OP_LITERAL    = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] copy_offset;
    logic [23:0] run_length;
    logic [7:0]  literal;
    logic        literal_last;
    logic        truncated;
  } out_t;

  // classified byte handed from front to back
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [2:0] fidx;      // copy field index: 0..3 offset, 4..6 length
    logic       emit;      // transaction produces a result
    logic       done;      // copy instruction complete
    logic       lit_last;
    logic       trunc;
  } op_t;

endpackage

`default_nettype wire

@@ rtl/core/delta_copy_insert_parser.sv @@
// Top level of the delta copy/insert instruction parser.
// Depends on dcip_pkg, dcip_front, dcip_back and dcip_fifo.
//
// Takes one byte of a pack delta instruction stream per cycle and produces
// copy results (offset, length), insert headers and one result per literal
// byte, with last-literal and truncation flags. A byte is taken every cycle
// while the parser is not backed up. The front end tracks instruction state
// only, a MID_DEPTH-entry queue decouples it from the back end that gathers
// copy fields, and an OUT_DEPTH-entry queue holds results until popped.
`default_nettype none

module delta_copy_insert_parser #(
  parameter int unsigned MID_DEPTH = dcip_pkg::MidDepth,
  parameter int unsigned OUT_DEPTH = dcip_pkg::OutDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire dcip_pkg::in_t   in_i,
  output logic                 empty,
  input  wire logic            pop,
  output dcip_pkg::out_t       result_o
);
  import dcip_pkg::*;

  op_t  front_op, mid_op;
  out_t back_res;
  logic accept, mid_empty, mid_take, res_full, res_push;

  assign accept = push && !full;

  dcip_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .op_o     (front_op)
  );

  dcip_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_op),
    .full_o  (full),
    .pop_i   (mid_take),
    .rdata_o (mid_op),
    .empty_o (mid_empty)
  );

  dcip_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (mid_op),
    .op_valid_i (!mid_empty),
    .op_take_o  (mid_take),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (back_res)
  );

  dcip_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

@@ rtl/core/dcip_fifo.sv @@
// Small register FIFO used between front and back and at the result side.
// Generic width and depth; no package dependency.
`default_nettype none

module dcip_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = data_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dcip_front.sv @@
// Front end: tracks the instruction grammar and classifies each input byte.
// Depends on dcip_pkg.
`default_nettype none

module dcip_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire dcip_pkg::in_t  in_i,
  output dcip_pkg::op_t       op_o
);
  import dcip_pkg::*;

  typedef enum logic [1:0] {
    MODE_CMD  = 2'd0,
    MODE_COPY = 2'd1,
    MODE_INS  = 2'd2
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [6:0] pend_q, pend_d;
  logic [6:0] lits_q, lits_d;
  logic [2:0] idx;
  logic       fin;

  assign fin = in_i.final_byte;

  // lowest pending field
  always_comb begin
    idx = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (pend_q[i]) begin
        idx = 3'(i);
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    lits_d = lits_q;
    op_o   = '0;
    op_o.data = in_i.data_byte;
    unique case (mode_q)
      MODE_COPY: begin
        pend_d       = pend_q & (pend_q - 7'd1);
        op_o.op      = OP_COPY_FIELD;
        op_o.fidx    = idx;
        op_o.done    = (pend_d == '0);
        op_o.emit    = op_o.done || fin;
        op_o.trunc   = fin && !op_o.done;
        mode_d       = op_o.done ? MODE_CMD : MODE_COPY;
      end
      MODE_INS: begin
        lits_d        = lits_q - 7'd1;
        op_o.op       = OP_LITERAL;
        op_o.emit     = 1'b1;
        op_o.lit_last = (lits_d == '0);
        op_o.trunc    = fin && (lits_d != '0);
        mode_d        = (lits_d == '0) ? MODE_CMD : MODE_INS;
      end
      default: begin
        if (in_i.data_byte[7]) begin
          pend_d     = in_i.data_byte[6:0];
          op_o.op    = OP_COPY_START;
          op_o.done  = (pend_d == '0);
          op_o.emit  = op_o.done || fin;
          op_o.trunc = fin && !op_o.done;
          mode_d     = op_o.done ? MODE_CMD : MODE_COPY;
        end else begin
          lits_d     = in_i.data_byte[6:0];
          op_o.op    = OP_INSERT;
          op_o.emit  = 1'b1;
          op_o.trunc = fin && (lits_d != '0);
          mode_d     = (lits_d != '0) ? MODE_INS : MODE_CMD;
        end
      end
    endcase
    if (fin) begin
      mode_d = MODE_CMD;
      pend_d = '0;
      lits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CMD;
      pend_q <= '0;
      lits_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      lits_q <= lits_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dcip_back.sv @@
// Back end: gathers copy fields and forms result transactions.
// Depends on dcip_pkg.
`default_nettype none

module dcip_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dcip_pkg::op_t  op_i,
  input  wire logic           op_valid_i,
  output logic                op_take_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output dcip_pkg::out_t      res_o
);
  import dcip_pkg::*;

  logic [31:0] off_q, off_d;
  logic [23:0] len_q, len_d;

  assign op_take_o  = op_valid_i && (!op_i.emit || !res_full_i);
  assign res_push_o = op_take_o && op_i.emit;

  always_comb begin
    off_d = off_q;
    len_d = len_q;
    res_o = '0;
    res_o.truncated = op_i.trunc;
    unique case (op_i.op)
      OP_COPY_START: begin
        off_d            = '0;
        len_d            = '0;
        res_o.kind       = KIND_COPY;
        res_o.run_length = op_i.done ? CopyLenZero : '0;
      end
      OP_COPY_FIELD: begin
        if (op_i.fidx[2]) begin
          len_d = len_q | ({16'd0, op_i.data} << {op_i.fidx[1:0], 3'b000});
        end else begin
          off_d = off_q | ({24'd0, op_i.data} << {op_i.fidx[1:0], 3'b000});
        end
        res_o.kind        = KIND_COPY;
        res_o.copy_offset = off_d;
        res_o.run_length  = (op_i.done && len_d == '0) ? CopyLenZero : len_d;
      end
      OP_INSERT: begin
        res_o.kind       = KIND_INSERT;
        res_o.run_length = {16'd0, op_i.data};
      end
      default: begin
        res_o.kind         = KIND_LITERAL;
        res_o.literal      = op_i.data;
        res_o.literal_last = op_i.lit_last;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      len_q <= '0;
    end else if (op_take_o) begin
      off_q <= off_d;
      len_q <= len_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dcip_checker.sv @@
// Port-level checks for the delta copy/insert instruction parser, with bind.
// Depends on dcip_pkg and delta_copy_insert_parser.
`default_nettype none

module dcip_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           empty,
  input wire logic           pop,
  input wire dcip_pkg::out_t result_o
);
  import dcip_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed");

  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.kind == KIND_COPY && !result_o.truncated)
      |-> (result_o.run_length != '0))
    else $error("complete copy with zero length");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.kind != KIND_COPY) |-> (result_o.copy_offset == '0))
    else $error("offset on non-copy result");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.literal_last)
      |-> (result_o.kind == KIND_LITERAL && !result_o.truncated))
    else $error("bad last-literal flag");

  a_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.kind == KIND_INSERT) |-> (result_o.run_length < 24'd128))
    else $error("insert count out of range");

endmodule

bind delta_copy_insert_parser dcip_checker u_dcip_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire
